// File: src/hnlc_pkg.sv
// Shared constants, item types, controller states and command/status bundles.
package hnlc_pkg;

    // Cache geometry
    localparam int PROGRAM_SLOTS     = 64;
    localparam int NAMES_PER_PROGRAM = 32;

    localparam int SLOT_W     = (PROGRAM_SLOTS > 1) ? $clog2(PROGRAM_SLOTS) : 1;
    localparam int PCNT_W     = $clog2(PROGRAM_SLOTS + 1);
    localparam int IDX_W      = $clog2(NAMES_PER_PROGRAM + 1);
    localparam int KEY_DEPTH  = PROGRAM_SLOTS * NAMES_PER_PROGRAM;
    localparam int KEY_AW     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int SLOT_OUT_W = 6;

    // djb2 hash
    localparam logic [31:0] HASH_START = 32'd5381;
    localparam int          HASH_SHIFT = 5;

    // Item function codes
    localparam logic FN_CHAR = 1'b0;
    localparam logic FN_FILL = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_MISS      = 3'd1,
        ST_UNCACHED  = 3'd2,
        ST_FILL_OK   = 3'd3,
        ST_FILL_NONE = 3'd4
    } t_status;

    typedef struct packed {
        logic               func;
        logic [31:0]        program_id;
        logic [7:0]         name_char;
        logic               last_char;
        logic signed [31:0] fill_location;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            status;
        logic signed [31:0]    location;
        logic [31:0]           hash_key;
        logic [SLOT_OUT_W-1:0] program_slot;
    } t_out_item;

    // One key list entry
    typedef struct packed {
        logic [31:0]        key;
        logic signed [31:0] loc;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_CNT_RD,
        S_CNT_LD,
        S_KEY_RD,
        S_KEY_CMP,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic char_acc;
        logic fill_acc;
        logic id_rd;
        logic id_next;
        logic id_hit;
        logic id_alloc;
        logic uncached;
        logic cnt_rd;
        logic cnt_ld;
        logic key_rd;
        logic key_next;
        logic key_hit;
        logic key_miss;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_hit;
        logic id_end;
        logic tbl_full;
        logic id_match;
        logic key_end;
        logic key_match;
        logic out_free;
    } t_stat;

endpackage

// File: src/hnlc_ram.sv
// Generic simple dual-port RAM with registered read.
module hnlc_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/hnlc_ctrl.sv
// Lookup controller: sequences hashing, slot search, key scan and result hand-off.
module hnlc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_func,
    input  logic             i_last,
    input  hnlc_pkg::t_stat  i_stat,
    output hnlc_pkg::t_cmd   o_cmd,
    output logic             o_in_stall,
    output hnlc_pkg::t_state o_state
);
    import hnlc_pkg::*;

    t_state r_state, n_state;
    t_cmd   w_cmd;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FN_FILL) begin
                        w_cmd.fill_acc = 1'b1;
                        n_state        = S_OUT;
                    end else begin
                        w_cmd.char_acc = 1'b1;
                        if (i_last) begin
                            n_state = i_stat.last_hit ? S_CNT_RD : S_SRCH_RD;
                        end
                    end
                end
            end
            S_SRCH_RD: begin
                if (i_stat.id_end) begin
                    if (i_stat.tbl_full) begin
                        w_cmd.uncached = 1'b1;
                        n_state        = S_OUT;
                    end else begin
                        w_cmd.id_alloc = 1'b1;
                        n_state        = S_CNT_RD;
                    end
                end else begin
                    w_cmd.id_rd = 1'b1;
                    n_state     = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.id_match) begin
                    w_cmd.id_hit = 1'b1;
                    n_state      = S_CNT_RD;
                end else begin
                    w_cmd.id_next = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_CNT_RD: begin
                w_cmd.cnt_rd = 1'b1;
                n_state      = S_CNT_LD;
            end
            S_CNT_LD: begin
                w_cmd.cnt_ld = 1'b1;
                n_state      = S_KEY_RD;
            end
            S_KEY_RD: begin
                if (i_stat.key_end) begin
                    w_cmd.key_miss = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    w_cmd.key_rd = 1'b1;
                    n_state      = S_KEY_CMP;
                end
            end
            S_KEY_CMP: begin
                if (i_stat.key_match) begin
                    w_cmd.key_hit = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    w_cmd.key_next = 1'b1;
                    n_state        = S_KEY_RD;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_state    = r_state;

endmodule

// File: src/hnlc_dp.sv
// Datapath: hash accumulator, slot table, per-slot key lists, pending miss and output register.
module hnlc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hnlc_pkg::t_in_item  i_item,
    input  hnlc_pkg::t_cmd      i_cmd,
    output hnlc_pkg::t_stat     o_stat,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output hnlc_pkg::t_out_item o_out_data
);
    import hnlc_pkg::*;

    logic [31:0]              r_hash;
    logic [31:0]              n_hash;
    logic [31:0]              r_key;
    logic [31:0]              r_prog;
    logic [31:0]              r_last_prog;
    logic [SLOT_W-1:0]        r_last_slot;
    logic [SLOT_W-1:0]        r_slot;
    logic [PCNT_W-1:0]        r_pcount;
    logic [PCNT_W-1:0]        r_pidx;
    logic [IDX_W-1:0]         r_kidx;
    logic [IDX_W-1:0]         r_cnt;
    logic [PROGRAM_SLOTS-1:0] r_cnt_vld;
    logic                     r_pend_vld;
    logic [SLOT_W-1:0]        r_pend_slot;
    logic [IDX_W-1:0]         r_pend_idx;
    logic [31:0]              r_pend_key;
    t_out_item                r_res;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic [31:0]              w_id_rdata;
    logic [IDX_W-1:0]         w_cnt_rdata;
    t_entry                   w_key_rdata;
    t_entry                   w_key_wdata;
    logic                     w_fill_ok;
    logic                     w_key_we;
    logic                     w_cnt_we;
    logic [KEY_AW-1:0]        w_key_waddr;
    logic [KEY_AW-1:0]        w_key_raddr;
    logic [IDX_W-1:0]         w_cnt_wdata;
    logic                     w_out_free;

    // djb2 step; a zero byte leaves the hash alone
    always_comb begin
        if (i_item.name_char != 8'd0) begin
            n_hash = r_hash + (r_hash << HASH_SHIFT) + 32'(i_item.name_char);
        end else begin
            n_hash = r_hash;
        end
    end

    // Fill write: lists are append-only, so the pending index is the list length
    assign w_fill_ok   = r_pend_vld && (r_pend_idx < IDX_W'(NAMES_PER_PROGRAM));
    assign w_key_we    = i_cmd.fill_acc && w_fill_ok;
    assign w_cnt_we    = w_key_we && (r_pend_key != 32'd0);
    assign w_cnt_wdata = r_pend_idx + IDX_W'(1);
    assign w_key_waddr = KEY_AW'(r_pend_slot) * KEY_AW'(NAMES_PER_PROGRAM)
                         + KEY_AW'(r_pend_idx);
    assign w_key_raddr = KEY_AW'(r_slot) * KEY_AW'(NAMES_PER_PROGRAM) + KEY_AW'(r_kidx);
    assign w_key_wdata.key = r_pend_key;
    assign w_key_wdata.loc = i_item.fill_location;

    // Program id table
    hnlc_ram #(
        .WIDTH (32),
        .DEPTH (PROGRAM_SLOTS)
    ) u_id_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.id_alloc),
        .i_wr_addr (r_pcount[SLOT_W-1:0]),
        .i_wr_data (r_prog),
        .i_rd_en   (i_cmd.id_rd),
        .i_rd_addr (r_pidx[SLOT_W-1:0]),
        .o_rd_data (w_id_rdata)
    );

    // Key list length per slot, gated by r_cnt_vld
    hnlc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PROGRAM_SLOTS)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_cnt_we),
        .i_wr_addr (r_pend_slot),
        .i_wr_data (w_cnt_wdata),
        .i_rd_en   (i_cmd.cnt_rd),
        .i_rd_addr (r_slot),
        .o_rd_data (w_cnt_rdata)
    );

    // Keys and locations
    hnlc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_key_we),
        .i_wr_addr (w_key_waddr),
        .i_wr_data (w_key_wdata),
        .i_rd_en   (i_cmd.key_rd),
        .i_rd_addr (w_key_raddr),
        .o_rd_data (w_key_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= HASH_START;
            r_last_prog <= 32'd0;
            r_last_slot <= '0;
            r_pcount    <= '0;
            r_cnt_vld   <= '0;
            r_pend_vld  <= 1'b0;
            r_pend_slot <= '0;
            r_pend_idx  <= '0;
            r_pend_key  <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.char_acc) begin
                if (i_item.last_char) begin
                    r_hash     <= HASH_START;
                    r_pend_vld <= 1'b0;
                end else begin
                    r_hash <= n_hash;
                end
            end
            if (i_cmd.fill_acc) begin
                r_pend_vld <= 1'b0;
            end
            if (w_cnt_we) begin
                r_cnt_vld[r_pend_slot] <= 1'b1;
            end
            if (i_cmd.id_alloc) begin
                r_pcount    <= r_pcount + PCNT_W'(1);
                r_last_prog <= r_prog;
                r_last_slot <= r_pcount[SLOT_W-1:0];
            end
            if (i_cmd.id_hit) begin
                r_last_prog <= r_prog;
                r_last_slot <= r_pidx[SLOT_W-1:0];
            end
            if (i_cmd.key_miss) begin
                r_pend_vld  <= 1'b1;
                r_pend_slot <= r_slot;
                r_pend_idx  <= r_kidx;
                r_pend_key  <= r_key;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.char_acc && i_item.last_char) begin
            r_key  <= n_hash;
            r_prog <= i_item.program_id;
            r_pidx <= '0;
            r_slot <= r_last_slot;
        end
        if (i_cmd.id_next) begin
            r_pidx <= r_pidx + PCNT_W'(1);
        end
        if (i_cmd.id_hit) begin
            r_slot <= r_pidx[SLOT_W-1:0];
        end
        if (i_cmd.id_alloc) begin
            r_slot <= r_pcount[SLOT_W-1:0];
        end
        if (i_cmd.cnt_ld) begin
            r_cnt  <= r_cnt_vld[r_slot] ? w_cnt_rdata : '0;
            r_kidx <= '0;
        end
        if (i_cmd.key_next) begin
            r_kidx <= r_kidx + IDX_W'(1);
        end
        if (i_cmd.fill_acc) begin
            r_res.status       <= w_fill_ok ? ST_FILL_OK : ST_FILL_NONE;
            r_res.location     <= i_item.fill_location;
            r_res.hash_key     <= r_pend_vld ? r_pend_key : 32'd0;
            r_res.program_slot <= r_pend_vld ? SLOT_OUT_W'(r_pend_slot) : '0;
        end
        if (i_cmd.uncached) begin
            r_res.status       <= ST_UNCACHED;
            r_res.location     <= 32'sd0;
            r_res.hash_key     <= r_key;
            r_res.program_slot <= '0;
        end
        if (i_cmd.key_hit) begin
            r_res.status       <= ST_HIT;
            r_res.location     <= w_key_rdata.loc;
            r_res.hash_key     <= r_key;
            r_res.program_slot <= SLOT_OUT_W'(r_slot);
        end
        if (i_cmd.key_miss) begin
            r_res.status       <= ST_MISS;
            r_res.location     <= 32'sd0;
            r_res.hash_key     <= r_key;
            r_res.program_slot <= SLOT_OUT_W'(r_slot);
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Status to controller
    assign o_stat.last_hit  = (i_item.program_id == r_last_prog);
    assign o_stat.id_end    = (r_pidx == r_pcount);
    assign o_stat.tbl_full  = (r_pcount == PCNT_W'(PROGRAM_SLOTS));
    assign o_stat.id_match  = (w_id_rdata == r_prog);
    assign o_stat.key_end   = (r_kidx == r_cnt);
    assign o_stat.key_match = (w_key_rdata.key == r_key);
    assign o_stat.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: src/hashed_name_location_cache.sv
// Non-final name characters: one per cycle, no result. Fill: hand-off, then result load.
// Final character: unless the id was last used, id-table entries are read, then compared, in
// turn, and a slot is allocated if none matches (uncached if the table is full); the list
// length and then the keys are read the same way from registered-read RAMs; the result loads.
// Next item accepted once the result loads; an output stall holds it.
// Synchronous active-low reset; no clearing pass, the block is ready right after reset.
module hashed_name_location_cache (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hnlc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hnlc_pkg::t_out_item o_out_data
);
    import hnlc_pkg::*;

    t_cmd   w_cmd;
    t_stat  w_stat;
    t_state w_state;

    // Sequencer
    hnlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_last     (i_in_data.last_char),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall),
        .o_state    (w_state)
    );

    // Storage and arithmetic
    hnlc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A fill item always goes straight to result hand-off
    a_fill_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.func == FN_FILL) |=> (w_state == S_OUT))
        else $error("fill item did not go to result hand-off");

    // A non-final character makes no result and keeps the block open
    a_char_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.func == FN_CHAR && !i_in_data.last_char)
        |=> (w_state == S_IDLE))
        else $error("non-final character left idle");

    // A new result only appears out of the hand-off state
    a_out_from_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(w_state) == S_OUT))
        else $error("result appeared outside hand-off");

endmodule
